/* design/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, clk, rst_n) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Assert a property on the standard clock and reset of the block.
`define ASSERT_STD(label, prop) `ASSERT_CLK(label, prop, clk_i, rst_ni)

`endif

/* design/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Opcodes and port widths shared by the ALU and its checker.
// ----------------------------------------------------------------------------
package fpa_pkg;

  // Width of the opcode field and of the data ports.
  localparam int unsigned OP_WIDTH = 4;
  localparam int unsigned IO_WIDTH = 32;

  // Operation codes.
  localparam logic [OP_WIDTH-1:0] OP_ADD   = 4'd0;
  localparam logic [OP_WIDTH-1:0] OP_SUB   = 4'd1;
  localparam logic [OP_WIDTH-1:0] OP_MUL   = 4'd2;
  localparam logic [OP_WIDTH-1:0] OP_DIV   = 4'd3;
  localparam logic [OP_WIDTH-1:0] OP_NEG   = 4'd4;
  localparam logic [OP_WIDTH-1:0] OP_ROUND = 4'd5;
  localparam logic [OP_WIDTH-1:0] OP_ABS   = 4'd6;
  localparam logic [OP_WIDTH-1:0] OP_FLOOR = 4'd7;
  localparam logic [OP_WIDTH-1:0] OP_CEIL  = 4'd8;

endpackage

/* design/fpa_div.sv */
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage.
// ----------------------------------------------------------------------------
module fpa_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 40
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [QW-1:0] dividend_i,
  input  logic [DW-1:0] divisor_i,
  output logic [QW-1:0] quotient_o
);

  // Per-stage partial remainder, dividend/quotient word and divisor.
  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] dq_q  [QW];
  logic [DW-1:0] dvs_q [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] dq_in;
    logic [DW-1:0] dvs_in;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic [DW-1:0] rem_d;
    logic          bit_d;

    // The first stage takes the unregistered input, the others the stage before.
    if (k == 0) begin : g_head
      assign rem_in = '0;
      assign dq_in  = dividend_i;
      assign dvs_in = divisor_i;
    end else begin : g_body
      assign rem_in = rem_q[k-1];
      assign dq_in  = dq_q[k-1];
      assign dvs_in = dvs_q[k-1];
    end

    // Shift in the next dividend bit and try to subtract the divisor.
    always_comb begin
      shifted = {rem_in, dq_in[QW-1]};
      diff    = shifted - {1'b0, dvs_in};
      bit_d   = ~diff[DW];
      rem_d   = bit_d ? diff[DW-1:0] : shifted[DW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        dq_q[k]  <= {dq_in[QW-2:0], bit_d};
        dvs_q[k] <= dvs_in;
      end
    end
  end

  assign quotient_o = dq_q[QW-1];

endmodule

/* design/fixed_point_alu_q24_8_top.sv */
// Throughput: one item per cycle while the output is not stalled; the divider has one register stage per quotient bit.
// A stalled output freezes the whole pipeline; bubbles are not collapsed.
// Reset clears all valid bits asynchronously; payload registers are not reset.
// ----------------------------------------------------------------------------
// Signed fixed-point ALU
// Add, subtract, multiply, divide, negate, abs, round, floor and ceil.
// ----------------------------------------------------------------------------
module fixed_point_alu_q24_8_top
  import fpa_pkg::*;
#(
  parameter int unsigned FRAC_BITS  = 8,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [OP_WIDTH-1:0]        opcode_i,
  input  logic signed [IO_WIDTH-1:0] operand_a_i,
  input  logic signed [IO_WIDTH-1:0] operand_b_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [IO_WIDTH-1:0] result_o,
  output logic                       divide_by_zero_o
);

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned QW = DATA_WIDTH + FRAC_BITS;

  typedef struct packed {
    logic [OP_WIDTH-1:0] op;
    logic [DW-1:0]       res;
    logic                neg;
    logic                dz;
  } side_t;

  logic en;

  // The pipeline advances unless a finished item is held at the output.
  assign en         = ~(out_valid_o & out_stall_i);
  assign in_stall_o = ~en;

  // Stage 1: capture the operands, trimmed to the data width.
  logic                 s1_valid_q;
  logic [OP_WIDTH-1:0]  s1_op_q;
  logic signed [DW-1:0] s1_a_q, s1_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_op_q <= opcode_i;
      s1_a_q  <= operand_a_i[DW-1:0];
      s1_b_q  <= operand_b_i[DW-1:0];
    end
  end

  // Stage 2: product, magnitudes and the simple operations.
  logic [DW-1:0]  amag, bmag, floor_v, simple_d;
  logic [DW:0]    round_t;
  logic           frac_nz;
  logic           s2_valid_q;
  logic [OP_WIDTH-1:0] s2_op_q;
  logic signed [2*DW-1:0] s2_prod_q;
  logic [DW-1:0]  s2_simple_q, s2_amag_q, s2_bmag_q;
  logic           s2_neg_q, s2_dz_q;

  always_comb begin
    amag     = s1_a_q[DW-1] ? DW'(-s1_a_q) : DW'(s1_a_q);
    bmag     = s1_b_q[DW-1] ? DW'(-s1_b_q) : DW'(s1_b_q);
    floor_v  = DW'(s1_a_q >>> FRAC_BITS);
    frac_nz  = |s1_a_q[FRAC_BITS-1:0];
    round_t  = ({1'b0, amag} + (DW+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    simple_d = '0;
    unique case (s1_op_q)
      OP_ADD:   simple_d = DW'(s1_a_q + s1_b_q);
      OP_SUB:   simple_d = DW'(s1_a_q - s1_b_q);
      OP_NEG:   simple_d = DW'(-s1_a_q);
      OP_ABS:   simple_d = amag;
      OP_ROUND: simple_d = s1_a_q[DW-1] ? DW'(-round_t) : round_t[DW-1:0];
      OP_FLOOR: simple_d = floor_v;
      OP_CEIL:  simple_d = floor_v + DW'(frac_nz);
      default:  simple_d = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_op_q     <= s1_op_q;
      s2_prod_q   <= (2*DW)'(s1_a_q) * (2*DW)'(s1_b_q);
      s2_simple_q <= simple_d;
      s2_amag_q   <= amag;
      s2_bmag_q   <= bmag;
      s2_neg_q    <= s1_a_q[DW-1] ^ s1_b_q[DW-1];
      s2_dz_q     <= (s1_op_q == OP_DIV) && (s1_b_q == '0);
    end
  end

  // Stage 3: select the multiply result; launch the divider.
  logic  s3_valid_q;
  side_t s3_side_q;
  logic [DW-1:0] s3_amag_q, s3_bmag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else if (en) begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_side_q.op  <= s2_op_q;
      s3_side_q.res <= (s2_op_q == OP_MUL) ? s2_prod_q[DW+FRAC_BITS-1:FRAC_BITS]
                                           : s2_simple_q;
      s3_side_q.neg <= s2_neg_q;
      s3_side_q.dz  <= s2_dz_q;
      s3_amag_q     <= s2_amag_q;
      s3_bmag_q     <= s2_bmag_q;
    end
  end

  logic [QW-1:0] quotient;

  fpa_div #(
    .DW(DW),
    .QW(QW)
  ) u_div (
    .clk_i      (clk_i),
    .en_i       (en),
    .dividend_i ({s3_amag_q, {FRAC_BITS{1'b0}}}),
    .divisor_i  (s3_bmag_q),
    .quotient_o (quotient)
  );

  // Sideband and valid bits travel alongside the divider stages.
  logic  dl_valid_q [QW];
  side_t dl_side_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_delay
    logic  valid_in;
    side_t side_in;

    if (k == 0) begin : g_head
      assign valid_in = s3_valid_q;
      assign side_in  = s3_side_q;
    end else begin : g_body
      assign valid_in = dl_valid_q[k-1];
      assign side_in  = dl_side_q[k-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dl_valid_q[k] <= 1'b0;
      end else if (en) begin
        dl_valid_q[k] <= valid_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dl_side_q[k] <= side_in;
      end
    end
  end

  // Output stage: pick the divide result or the carried result.
  side_t                side_f;
  logic signed [DW-1:0] res_d;
  logic signed [DW-1:0] res_q;
  logic                 dz_q, out_valid_q;

  always_comb begin
    side_f = dl_side_q[QW-1];
    res_d  = side_f.res;
    if (side_f.op == OP_DIV) begin
      if (side_f.dz) begin
        res_d = {1'b0, {(DW-1){1'b1}}};
      end else begin
        res_d = side_f.neg ? -quotient[DW-1:0] : quotient[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dl_valid_q[QW-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_q <= res_d;
      dz_q  <= side_f.dz;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign result_o         = IO_WIDTH'(res_q);
  assign divide_by_zero_o = dz_q;

endmodule

/* design/fpa_chk.sv */
// ----------------------------------------------------------------------------
// Fixed-point ALU port checker
// Checks handshake and result rules seen at the ALU ports.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fpa_chk
  import fpa_pkg::*;
#(
  parameter int unsigned DATA_WIDTH = 32
) (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       in_valid_i,
  input logic                       in_stall_o,
  input logic [OP_WIDTH-1:0]        opcode_i,
  input logic signed [IO_WIDTH-1:0] operand_a_i,
  input logic signed [IO_WIDTH-1:0] operand_b_i,
  input logic                       out_valid_o,
  input logic                       out_stall_i,
  input logic signed [IO_WIDTH-1:0] result_o,
  input logic                       divide_by_zero_o
);

  localparam logic signed [IO_WIDTH-1:0] MAX_POS = IO_WIDTH'((64'd1 << (DATA_WIDTH - 1)) - 1);

  // A stalled output item keeps its valid and payload.
  `ASSERT_STD(a_out_hold, out_valid_o && out_stall_i |=> out_valid_o && $stable(result_o) && $stable(divide_by_zero_o))

  // The input is stalled only while an output item is held back.
  `ASSERT_STD(a_stall_cause, in_stall_o |-> out_valid_o && out_stall_i)

  // A divide by zero always delivers the largest positive value.
  `ASSERT_STD(a_dz_value, out_valid_o && divide_by_zero_o |-> result_o == MAX_POS)

endmodule

bind fixed_point_alu_q24_8_top fpa_chk #(.DATA_WIDTH(DATA_WIDTH)) u_fpa_chk (.*);
